/* sv/assert_macros.svh */
// Assertion macros shared by the line framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define CLF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("clf assertion failed");
// Check that a condition never holds outside reset.
`define CLF_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("clf forbidden condition seen");
`else
`define CLF_ASSERT(label, clk, rst, prop)
`define CLF_NEVER(label, clk, rst, cond)
`endif
`endif

/* sv/clf_pkg.sv */
// Shared constants for the line framer: action codes, characters, widths, default geometry.
package clf_pkg;

   // field widths of the request and response channels
   localparam int ACTION_W     = 2;
   localparam int BYTE_W       = 8;
   localparam int INDEX_W      = 6;
   localparam int SIZE_W       = 6;
   localparam int QUEUED_W     = 4;

   // default geometry
   localparam int LINE_BYTES_DEFAULT = 64;
   localparam int FIFO_LINES_DEFAULT = 8;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_RX   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   // line delimiters
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

endpackage

/* sv/clf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module clf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read; read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/crlf_line_framer_with_line_fifo_top.sv */
// Top level: CR/LF line assembler feeding a circular queue of stored lines.
// Received byte: no response; one byte per cycle sustained while busy is low.
// Pop/peek: first response in the cycle after the request, then one byte per cycle
// from the line RAM read port; busy stays high through the last byte of the line.
// Empty queue: one not-found response in the cycle after the request.
// Synchronous reset clears pointers, counts and control; RAMs are not cleared.
module crlf_line_framer_with_line_fifo_top #(
   parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEFAULT,
   parameter int FIFO_LINES = clf_pkg::FIFO_LINES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [clf_pkg::ACTION_W-1:0]  req_action,
   input  logic [clf_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [clf_pkg::BYTE_W-1:0]    rsp_line_byte,
   output logic [clf_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [clf_pkg::SIZE_W-1:0]    rsp_line_size,
   output logic                          rsp_last,
   output logic [clf_pkg::QUEUED_W-1:0]  rsp_queued_lines
);

   import clf_pkg::*;

   `include "assert_macros.svh"

   // geometry: one spare slot holds the line under construction
   localparam int LINE_CAP = LINE_BYTES - 1;
   localparam int SLOTS    = FIFO_LINES + 1;
   localparam int LW       = $clog2(LINE_BYTES);
   localparam int IW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
   localparam int SW       = $clog2(SLOTS);
   localparam int CW       = $clog2(FIFO_LINES + 1);
   localparam int DATA_DEPTH = SLOTS * (1 << IW);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_STREAM = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic          prev_cr_ff, prev_cr_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] out_idx_ff, out_idx_in;

   logic             accept;
   logic             do_commit;
   logic [LW-1:0]    idx_next;
   logic             last_beat;
   logic             pop_taken;

   logic             data_wr_en;
   logic [SW+IW-1:0] data_wr_addr;
   logic             data_rd_en;
   logic [SW+IW-1:0] data_rd_addr;
   logic [BYTE_W-1:0] data_rd_data;

   logic             len_wr_en;
   logic             len_rd_en;
   logic [LW-1:0]    len_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign idx_next  = out_idx_ff + LW'(1);
   assign last_beat = (idx_next == len_rd_data);
   assign pop_taken = accept && (req_action == ACT_POP) && (count_ff != '0);

   // line bytes of every slot
   clf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DATA_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (data_wr_en),
      .wr_addr(data_wr_addr),
      .wr_data(req_rx_byte),
      .rd_en  (data_rd_en),
      .rd_addr(data_rd_addr),
      .rd_data(data_rd_data)
   );

   // stored length of every slot
   clf_ram #(
      .WIDTH(LW),
      .DEPTH(SLOTS)
   ) u_len_ram (
      .clock  (clock),
      .wr_en  (len_wr_en),
      .wr_addr(wslot_ff),
      .wr_data(plen_ff),
      .rd_en  (len_rd_en),
      .rd_addr(rslot_ff),
      .rd_data(len_rd_data)
   );

   // decode requests, build lines in place, sequence line reads
   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      prev_cr_in   = prev_cr_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      cur_slot_in  = cur_slot_ff;
      count_in     = count_ff;
      out_idx_in   = out_idx_ff;
      do_commit    = 1'b0;
      data_wr_en   = 1'b0;
      data_wr_addr = {wslot_ff, plen_ff[IW-1:0]};
      data_rd_en   = 1'b0;
      data_rd_addr = {rslot_ff, {IW{1'b0}}};
      len_wr_en    = 1'b0;
      len_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action) inside
                  ACT_RX: begin
                     if (req_rx_byte == CHAR_CR) begin
                        do_commit  = 1'b1;
                        prev_cr_in = 1'b1;
                     end else if (req_rx_byte == CHAR_LF) begin
                        // swallow the LF of a CR LF pair
                        if (prev_cr_ff) begin
                           prev_cr_in = 1'b0;
                        end else begin
                           do_commit = 1'b1;
                        end
                     end else begin
                        prev_cr_in = 1'b0;
                        if (plen_ff < LW'(LINE_CAP)) begin
                           data_wr_en = 1'b1;
                           plen_in    = plen_ff + LW'(1);
                        end else begin
                           // full line: commit and drop this byte
                           do_commit = 1'b1;
                        end
                     end
                  end
                  ACT_POP, ACT_PEEK: begin
                     if (count_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        len_rd_en   = 1'b1;
                        data_rd_en  = 1'b1;
                        cur_slot_in = rslot_ff;
                        out_idx_in  = '0;
                        state_in    = ST_STREAM;
                        if (req_action == ACT_POP) begin
                           rslot_in = (rslot_ff == SW'(FIFO_LINES)) ? '0 : rslot_ff + SW'(1);
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STREAM: begin
            // prefetch the next byte while this one is shown
            data_rd_en   = 1'b1;
            data_rd_addr = {cur_slot_ff, idx_next[IW-1:0]};
            out_idx_in   = idx_next;
            if (last_beat) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // close the line: queue it if non-empty and there is room
      if (do_commit) begin
         plen_in = '0;
         if (plen_ff != '0 && count_ff < CW'(FIFO_LINES)) begin
            len_wr_en = 1'b1;
            wslot_in  = (wslot_ff == SW'(FIFO_LINES)) ? '0 : wslot_ff + SW'(1);
            count_in  = count_ff + CW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         plen_ff    <= '0;
         prev_cr_ff <= 1'b0;
         wslot_ff   <= '0;
         rslot_ff   <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         plen_ff    <= plen_in;
         prev_cr_ff <= prev_cr_in;
         wslot_ff   <= wslot_in;
         rslot_ff   <= rslot_in;
         count_ff   <= count_in;
      end
   end

   // stream position, no reset needed
   always_ff @(posedge clock) begin
      cur_slot_ff <= cur_slot_in;
      out_idx_ff  <= out_idx_in;
   end

   // response outputs
   assign rsp_valid        = (state_ff == ST_STREAM) || (state_ff == ST_EMPTY);
   assign rsp_found        = (state_ff == ST_STREAM);
   assign rsp_line_byte    = rsp_found ? data_rd_data : '0;
   assign rsp_byte_index   = rsp_found ? INDEX_W'(out_idx_ff) : '0;
   assign rsp_line_size    = rsp_found ? SIZE_W'(len_rd_data) : '0;
   assign rsp_last         = (state_ff == ST_EMPTY) || (rsp_found && last_beat);
   assign rsp_queued_lines = QUEUED_W'(count_ff);

   // checks
   `CLF_NEVER(a_count_range, clock, reset, count_ff > CW'(FIFO_LINES))
   `CLF_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (wslot_ff == rslot_ff))
   `CLF_ASSERT(a_pop_dec, clock, reset, pop_taken |=> (count_ff == $past(count_ff) - CW'(1)))
   `CLF_ASSERT(a_last_frees, clock, reset, (rsp_valid && rsp_last) |=> !busy)
   `CLF_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy)

endmodule
